### rtl/core/rfod_pkg.sv
`timescale 1ns / 1ps

package rfod_pkg;

   // Default build sizes
   localparam int DEPTH_DEF      = 64;
   localparam int WORD_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int SLOTS_W    = 7;
   localparam int OCC_OUT_W  = 6;
   localparam int FREE_OUT_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OVERWRITE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS     = 1'b1;

   // Register reset values
   localparam logic              OVERWRITE_RESET = 1'b0;
   localparam logic [SLOTS_W-1:0] SLOTS_RESET    = 7'd64;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

endpackage

### rtl/core/rfod_store.sv
`timescale 1ns / 1ps

module rfod_store #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32,
   parameter int PTR_W      = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PTR_W-1:0]      wr_addr,
   input  logic [WORD_WIDTH-1:0] wr_data,
   input  logic [PTR_W-1:0]      rd_addr,
   output logic [WORD_WIDTH-1:0] head_word
);

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  byp_ff;
   logic [WORD_WIDTH-1:0] byp_data_ff;

   // Write one entry, read the next head entry with a registered port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Capture a same-cycle write to the head entry
   always_ff @(posedge clock) begin
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   // Forward the fresh word over the stale read data
   assign head_word = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

### rtl/core/rfod_engine.sv
`timescale 1ns / 1ps

module rfod_engine #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32,
   parameter int PTR_W      = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            flush,
   input  logic                            overwrite_when_full,
   input  logic [rfod_pkg::SLOTS_W-1:0]    slots_in_use,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [WORD_WIDTH-1:0]           req_push_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [WORD_WIDTH-1:0]           rsp_pop_word,
   output logic                            rsp_evicted_oldest,
   output logic [rfod_pkg::OCC_OUT_W-1:0]  rsp_occupancy,
   output logic [rfod_pkg::FREE_OUT_W-1:0] rsp_free_slots,
   output logic [rfod_pkg::OCC_OUT_W-1:0]  rsp_contiguous_run,
   output logic                            rsp_is_full,
   output logic                            rsp_is_empty,
   output logic                            mem_wr_en,
   output logic [PTR_W-1:0]                mem_wr_addr,
   output logic [WORD_WIDTH-1:0]           mem_wr_data,
   output logic [PTR_W-1:0]                mem_rd_addr,
   input  logic [WORD_WIDTH-1:0]           head_word
);

   import rfod_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = (CNT_W > SLOTS_W) ? CNT_W : SLOTS_W;

   // Item register
   logic                  item_valid_ff, item_valid_in;
   logic                  item_op_ff;
   logic [WORD_WIDTH-1:0] item_word_ff;

   // Ring pointers
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic [WORD_WIDTH-1:0] rsp_pop_ff, rsp_pop_in;
   logic                  rsp_evict_ff, rsp_evict_in;
   logic [OCC_OUT_W-1:0]  rsp_occ_ff, rsp_occ_in;
   logic [FREE_OUT_W-1:0] rsp_free_ff, rsp_free_in;
   logic [OCC_OUT_W-1:0]  rsp_run_ff, rsp_run_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic          fire;
   logic          take;
   logic [CW-1:0] eff_slots;
   logic          full_now;
   logic          empty_now;
   logic [PTR_W-1:0] wr_step;
   logic [PTR_W-1:0] rd_step;
   logic [CW-1:0] occ;
   logic [CW-1:0] run;
   logic [CW-1:0] free;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CW-1:0] s);
      logic [CW-1:0] n;
      n = CW'(p) + CW'(1);
      return (n >= s) ? '0 : n[PTR_W-1:0];
   endfunction

   // Handshake: process when the result register can take a transaction
   assign fire      = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !fire;
   assign take      = req_valid && !req_stall;

   // Clamp the slot count into the legal range
   always_comb begin
      if (CW'(slots_in_use) < CW'(2)) begin
         eff_slots = CW'(2);
      end else if (CW'(slots_in_use) > CW'(DEPTH)) begin
         eff_slots = CW'(DEPTH);
      end else begin
         eff_slots = CW'(slots_in_use);
      end
   end

   assign wr_step   = advance(wr_ff, eff_slots);
   assign rd_step   = advance(rd_ff, eff_slots);
   assign full_now  = (wr_step == rd_ff);
   assign empty_now = (wr_ff == rd_ff);

   // Apply the push or pop to the pointers
   always_comb begin
      wr_in           = wr_ff;
      rd_in           = rd_ff;
      mem_wr_en       = 1'b0;
      rsp_accepted_in = 1'b0;
      rsp_evict_in    = 1'b0;
      rsp_pop_in      = '0;
      if (flush) begin
         wr_in = '0;
         rd_in = '0;
      end else if (fire) begin
         if (item_op_ff == OP_PUSH) begin
            if (!full_now || overwrite_when_full) begin
               if (full_now) begin
                  rd_in        = rd_step;
                  rsp_evict_in = 1'b1;
               end
               mem_wr_en       = 1'b1;
               wr_in           = wr_step;
               rsp_accepted_in = 1'b1;
            end
         end else begin
            if (!empty_now) begin
               rsp_pop_in      = head_word;
               rd_in           = rd_step;
               rsp_accepted_in = 1'b1;
            end
         end
      end
   end

   assign mem_wr_addr = wr_ff;
   assign mem_wr_data = item_word_ff;
   assign mem_rd_addr = rd_in;

   // Status after the step
   always_comb begin
      if (wr_in >= rd_in) begin
         occ = CW'(wr_in) - CW'(rd_in);
         run = occ;
      end else begin
         run = eff_slots - CW'(rd_in);
         occ = run + CW'(wr_in);
      end
      free         = eff_slots - occ;
      rsp_occ_in   = occ[OCC_OUT_W-1:0];
      rsp_run_in   = run[OCC_OUT_W-1:0];
      rsp_free_in  = free[FREE_OUT_W-1:0];
      rsp_full_in  = (advance(wr_in, eff_slots) == rd_in);
      rsp_empty_in = (wr_in == rd_in);
   end

   // Result valid: set on processing, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign item_valid_in = take ? 1'b1 : (fire ? 1'b0 : item_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wr_ff         <= '0;
         rd_ff         <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         wr_ff         <= wr_in;
         rd_ff         <= rd_in;
      end
   end

   // Hold the incoming transaction
   always_ff @(posedge clock) begin
      if (take) begin
         item_op_ff   <= req_op;
         item_word_ff <= req_push_word;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_pop_ff      <= rsp_pop_in;
         rsp_evict_ff    <= rsp_evict_in;
         rsp_occ_ff      <= rsp_occ_in;
         rsp_free_ff     <= rsp_free_in;
         rsp_run_ff      <= rsp_run_in;
         rsp_full_ff     <= rsp_full_in;
         rsp_empty_ff    <= rsp_empty_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_pop_word       = rsp_pop_ff;
   assign rsp_evicted_oldest = rsp_evict_ff;
   assign rsp_occupancy      = rsp_occ_ff;
   assign rsp_free_slots     = rsp_free_ff;
   assign rsp_contiguous_run = rsp_run_ff;
   assign rsp_is_full        = rsp_full_ff;
   assign rsp_is_empty       = rsp_empty_ff;

   // Pointers stay inside the active ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(wr_ff) < eff_slots) && (CW'(rd_ff) < eff_slots))
      else $error("ring pointer outside active slots");

   // An eviction comes only with a stored push
   a_evict_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evict_ff |-> rsp_accepted_ff)
      else $error("eviction without accepted push");

   // A successful pop moves the read pointer
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      fire && !flush && (item_op_ff == OP_POP) && !empty_now |=> rd_ff != $past(rd_ff))
      else $error("pop did not advance read pointer");

   // An empty report carries zero occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> (rsp_occ_ff == '0) && (rsp_run_ff == '0))
      else $error("empty result with nonzero occupancy");

   // Stall only while a transaction sits in the item register
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff)
      else $error("input stalled with no held transaction");

endmodule

### rtl/core/ring_fifo_overwrite_or_drop_unit.sv
`timescale 1ns / 1ps

// Requests pass through the input register and then the result register.
// Throughput: one push or pop per cycle while the result is not stalled; the pointer
// update and the registered head-word read of the storage happen together. A stalled
// result holds the next request in the input register until the result is taken.
// Reset (synchronous): pointers cleared, overwrite off, 64 slots in use,
// storage contents undefined until written.
module ring_fifo_overwrite_or_drop_unit #(
   parameter int DEPTH      = rfod_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = rfod_pkg::WORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rfod_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfod_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [WORD_WIDTH-1:0]           req_push_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [WORD_WIDTH-1:0]           rsp_pop_word,
   output logic                            rsp_evicted_oldest,
   output logic [rfod_pkg::OCC_OUT_W-1:0]  rsp_occupancy,
   output logic [rfod_pkg::FREE_OUT_W-1:0] rsp_free_slots,
   output logic [rfod_pkg::OCC_OUT_W-1:0]  rsp_contiguous_run,
   output logic                            rsp_is_full,
   output logic                            rsp_is_empty
);

   import rfod_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   logic               overwrite_ff;
   logic [SLOTS_W-1:0] slots_ff;
   logic               flush;

   logic                  mem_wr_en;
   logic [PTR_W-1:0]      mem_wr_addr;
   logic [WORD_WIDTH-1:0] mem_wr_data;
   logic [PTR_W-1:0]      mem_rd_addr;
   logic [WORD_WIDTH-1:0] head_word;

   // A slot-count write empties the ring
   assign flush = csr_write_enable && (csr_index == CSR_SLOTS);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         overwrite_ff <= OVERWRITE_RESET;
         slots_ff     <= SLOTS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OVERWRITE: overwrite_ff <= csr_write_data[0];
            CSR_SLOTS:     slots_ff     <= csr_write_data[SLOTS_W-1:0];
            default:       ;
         endcase
      end
   end

   rfod_engine #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .PTR_W      (PTR_W)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .flush               (flush),
      .overwrite_when_full (overwrite_ff),
      .slots_in_use        (slots_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_push_word       (req_push_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_pop_word        (rsp_pop_word),
      .rsp_evicted_oldest  (rsp_evicted_oldest),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_free_slots      (rsp_free_slots),
      .rsp_contiguous_run  (rsp_contiguous_run),
      .rsp_is_full         (rsp_is_full),
      .rsp_is_empty        (rsp_is_empty),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_addr         (mem_rd_addr),
      .head_word           (head_word)
   );

   rfod_store #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .PTR_W      (PTR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr   (mem_rd_addr),
      .head_word (head_word)
   );

endmodule

### bench/ring_fifo_overwrite_or_drop_checker.sv
`timescale 1ns / 1ps

module ring_fifo_overwrite_or_drop_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [rfod_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [rfod_pkg::CSR_DATA_W-1:0]           csr_write_data,
   input  logic                                      req_valid,
   input  logic                                      req_stall,
   input  logic                                      req_op,
   input  logic [rfod_pkg::WORD_WIDTH_DEF-1:0]       req_push_word,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   input  logic                                      rsp_accepted,
   input  logic [rfod_pkg::WORD_WIDTH_DEF-1:0]       rsp_pop_word,
   input  logic                                      rsp_evicted_oldest,
   input  logic [rfod_pkg::OCC_OUT_W-1:0]            rsp_occupancy,
   input  logic [rfod_pkg::FREE_OUT_W-1:0]           rsp_free_slots,
   input  logic [rfod_pkg::OCC_OUT_W-1:0]            rsp_contiguous_run,
   input  logic                                      rsp_is_full,
   input  logic                                      rsp_is_empty,
   output int                                        mismatch_count,
   output int                                        pending_results
);

   import rfod_pkg::*;

   localparam int RING_DEPTH  = DEPTH_DEF;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                      accepted;
      logic [WORD_WIDTH_DEF-1:0] pop_word;
      logic                      evicted;
      logic [OCC_OUT_W-1:0]      occupancy;
      logic [FREE_OUT_W-1:0]     free_slots;
      logic [OCC_OUT_W-1:0]      run_length;
      logic                      full;
      logic                      empty;
   } fifo_status_type;

   // Shadow copy of the ring and its settings
   logic [WORD_WIDTH_DEF-1:0] ring_words [RING_DEPTH];
   int unsigned               wr_slot;
   int unsigned               rd_slot;
   logic                      overwrite_on;
   logic [SLOTS_W-1:0]        slots_reg;
   fifo_status_type           status_q [$];
   int                        fail_total;

   // Clamp the programmed slot count to the usable range
   function automatic int unsigned ring_slots();
      if (slots_reg < 2) return 2;
      if (slots_reg > RING_DEPTH) return RING_DEPTH;
      return 32'(slots_reg);
   endfunction

   function automatic int unsigned next_slot(int unsigned p, int unsigned s);
      return (p + 1 >= s) ? 0 : p + 1;
   endfunction

   // Full when the read pointer sits one past the write pointer, ring-wise
   function automatic logic ring_full(int unsigned s);
      if (rd_slot != 0) return (rd_slot - 1) == wr_slot;
      return wr_slot == s - 1;
   endfunction

   // Apply one transaction to the shadow ring and return the status it reports
   function automatic fifo_status_type predict_status(logic op,
                                                     logic [WORD_WIDTH_DEF-1:0] word);
      fifo_status_type st;
      int unsigned     s;
      int unsigned     held;
      int unsigned     run;
      logic            store_it;
      st = '0;
      s  = ring_slots();
      if (op == OP_PUSH) begin
         store_it = 1'b1;
         if (ring_full(s)) begin
            if (overwrite_on) begin
               rd_slot    = next_slot(rd_slot, s);
               st.evicted = 1'b1;
            end else begin
               store_it = 1'b0;
            end
         end
         if (store_it) begin
            ring_words[wr_slot] = word;
            wr_slot     = next_slot(wr_slot, s);
            st.accepted = 1'b1;
         end
      end else if (wr_slot != rd_slot) begin
         st.pop_word = ring_words[rd_slot];
         rd_slot     = next_slot(rd_slot, s);
         st.accepted = 1'b1;
      end
      if (wr_slot >= rd_slot) begin
         held = wr_slot - rd_slot;
         run  = held;
      end else begin
         held = s - rd_slot + wr_slot;
         run  = s - rd_slot;
      end
      st.occupancy  = OCC_OUT_W'(held);
      st.free_slots = FREE_OUT_W'(s - held);
      st.run_length = OCC_OUT_W'(run);
      st.full       = ring_full(s);
      st.empty      = (wr_slot == rd_slot);
      return st;
   endfunction

   function automatic string show(fifo_status_type st);
      return $sformatf("acc=%0b pop=%h evict=%0b occ=%0d free=%0d run=%0d full=%0b empty=%0b",
                       st.accepted, st.pop_word, st.evicted, st.occupancy, st.free_slots,
                       st.run_length, st.full, st.empty);
   endfunction

   always @(posedge clock) begin
      fifo_status_type got;
      fifo_status_type want;
      if (reset) begin
         status_q.delete();
         wr_slot      = 0;
         rd_slot      = 0;
         overwrite_on = OVERWRITE_RESET;
         slots_reg    = SLOTS_RESET;
         fail_total   = 0;
         for (int i = 0; i < RING_DEPTH; i++) ring_words[i] = '0;
      end else begin
         // Compare each returned transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_accepted, rsp_pop_word, rsp_evicted_oldest, rsp_occupancy,
                   rsp_free_slots, rsp_contiguous_run, rsp_is_full, rsp_is_empty};
            if (status_q.size() == 0) begin
               fail_total++;
               if (fail_total <= MAX_REPORTS)
                  $display("%t unexpected result: %s", $realtime, show(got));
            end else begin
               want = status_q.pop_front();
               if (got !== want) begin
                  fail_total++;
                  if (fail_total <= MAX_REPORTS) begin
                     $display("%t result mismatch", $realtime);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(got));
                  end
               end
            end
         end
         // Predict the status of each accepted request
         if (req_valid && !req_stall)
            status_q.push_back(predict_status(req_op, req_push_word));
         // Track register writes; a slot-count write flushes the ring
         if (csr_write_enable) begin
            case (csr_index)
               CSR_OVERWRITE: overwrite_on = csr_write_data[0];
               CSR_SLOTS: begin
                  slots_reg = csr_write_data;
                  wr_slot   = 0;
                  rd_slot   = 0;
               end
               default: ;
            endcase
         end
      end
      mismatch_count  <= fail_total;
      pending_results <= status_q.size();
   end

endmodule

### bench/ring_fifo_overwrite_or_drop_unit_test.sv
`timescale 1ns / 1ps

module ring_fifo_overwrite_or_drop_unit_test;
   import rfod_pkg::*;

   localparam int HOLD_CYCLES    = 150;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 10;
   localparam int IDLE_PCT       = 12;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index        = CSR_OVERWRITE;
   logic [CSR_DATA_W-1:0]     csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_op           = OP_PUSH;
   logic [WORD_WIDTH_DEF-1:0] req_push_word    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic                      rsp_accepted;
   logic [WORD_WIDTH_DEF-1:0] rsp_pop_word;
   logic                      rsp_evicted_oldest;
   logic [OCC_OUT_W-1:0]      rsp_occupancy;
   logic [FREE_OUT_W-1:0]     rsp_free_slots;
   logic [OCC_OUT_W-1:0]      rsp_contiguous_run;
   logic                      rsp_is_full;
   logic                      rsp_is_empty;

   int   mismatch_count;
   int   pending_results;
   int   quiet_cycles = 0;
   int   holds_asked  = 0;
   logic gaps_off     = 1'b0;

   // Per-phase settings: slot count written, overwrite bit, push share, length
   int phase_slots [PHASES] = '{0, 127, 5, 2, 64, 17, 1, 3, 9, 65};
   int phase_ovw   [PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0, 1, 0};
   int phase_push  [PHASES] = '{80, 90, 50, 60, 92, 45, 70, 75, 35, 60};
   int phase_items [PHASES] = '{55, 110, 55, 55, 130, 55, 45, 45, 55, 60};

   ring_fifo_overwrite_or_drop_unit dut (.*);

   ring_fifo_overwrite_or_drop_checker scoreboard (.*);

   always #1 clock = ~clock;

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** ring_fifo_overwrite_or_drop_unit: FAILED **");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin
      int holds_served;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !gaps_off && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Offer one transaction and hold it until the block takes it
   task automatic send_item(input logic op, input logic [WORD_WIDTH_DEF-1:0] word);
      if (!gaps_off && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_push_word <= word;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] ovw_data,
                                 input logic [CSR_DATA_W-1:0] slots_data);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_OVERWRITE;
      csr_write_data   <= ovw_data;
      @(posedge clock);
      csr_index        <= CSR_SLOTS;
      csr_write_data   <= slots_data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [WORD_WIDTH_DEF-1:0] word;
      int                        pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default settings: pop while empty, extreme words, drain to empty
      send_item(OP_POP, '0);
      send_item(OP_PUSH, '0);
      send_item(OP_PUSH, '1);
      send_item(OP_PUSH, 32'h5A5A_C3C3);
      repeat (4) send_item(OP_POP, '0);

      // Slot count below range acts as two; drop mode refuses a push when full
      drain_results();
      write_settings({6'h3F, 1'b0}, 7'd0);
      send_item(OP_PUSH, 32'h0000_1234);
      send_item(OP_PUSH, 32'h0000_9999);
      send_item(OP_POP, '0);
      send_item(OP_POP, '0);
      send_item(OP_PUSH, 32'hAAAA_5555);

      // Rewriting the same slot count flushes; overwrite evicts the oldest
      drain_results();
      write_settings({6'h00, 1'b1}, 7'd0);
      send_item(OP_POP, '0);
      send_item(OP_PUSH, 32'h1111_1111);
      send_item(OP_PUSH, 32'h2222_2222);
      send_item(OP_POP, '0);

      drain_results();
      write_settings({6'h15, 1'b1}, 7'd3);
      for (int i = 0; i < 4; i++) send_item(OP_PUSH, 32'hC0DE_0000 + i);
      repeat (3) send_item(OP_POP, '0);

      // Random phases across slot counts and both full policies
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         write_settings({(CSR_DATA_W-1)'($urandom_range(0, 63)), 1'(phase_ovw[p])},
                        CSR_DATA_W'(phase_slots[p]));
         gaps_off <= (p == 3);
         for (int i = 0; i < phase_items[p]; i++) begin
            if (p == 4 && i == 10) holds_asked <= holds_asked + 1;
            if (p == 2 && i == phase_items[p] / 2) drain_results();
            pick = $urandom_range(0, 7);
            word = (pick == 0) ? '0 : (pick == 1) ? '1 : WORD_WIDTH_DEF'($urandom());
            send_item(($urandom_range(0, 99) < phase_push[p]) ? OP_PUSH : OP_POP, word);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("** ring_fifo_overwrite_or_drop_unit: PASSED **");
      else
         $display("** ring_fifo_overwrite_or_drop_unit: FAILED **");
      $finish;
   end

endmodule

### ring_fifo_overwrite_or_drop_unit.f
rtl/core/rfod_pkg.sv
rtl/core/rfod_store.sv
rtl/core/rfod_engine.sv
rtl/core/ring_fifo_overwrite_or_drop_unit.sv
bench/ring_fifo_overwrite_or_drop_checker.sv
bench/ring_fifo_overwrite_or_drop_unit_test.sv
